@@ sv/mvna_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_pkg
// Shared types and constants of the vertex normal averaging block.
// ----------------------------------------------------------------------------
package mvna_pkg;

  localparam int IDX_W      = 10;
  localparam int OP_W       = 2;
  localparam int COORD_W    = 32;
  localparam int NRM_W      = 16;
  localparam int CNT_W      = 16;
  localparam int ACC_W      = 32;
  localparam int ONE_Q14    = 16384;
  localparam int Q_W        = 15;
  localparam int MAG_W      = 32;
  localparam int SUM_W      = 62;
  localparam int NUM_W      = 46;
  localparam int DIV_W      = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_TRI,
    CMD_READ,
    CMD_READ_ZERO,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx_a;
    logic [IDX_W-1:0]   idx_b;
    logic [IDX_W-1:0]   idx_c;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic empty;
    cmd_t head;
  } fifo_head_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_DIV,
    ST_TV0,
    ST_TV1,
    ST_TV2,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_ULEN,
    ST_UDIV,
    ST_CROSS,
    ST_ACC_R,
    ST_ACC_W
  } back_state_t;

  typedef enum logic [1:0] {
    PH_EDGE1,
    PH_EDGE2,
    PH_FACE
  } unit_phase_t;

  typedef logic [2:0][COORD_W-1:0] vert_t;

  typedef struct packed {
    logic [2:0][ACC_W-1:0] sum;
    logic [CNT_W-1:0]      cnt;
  } acc_ent_t;

endpackage

@@ sv/mvna_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_ifs
// Item and result channel interfaces with valid/ready transfers.
// ----------------------------------------------------------------------------
interface mvna_in_if;
  import mvna_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [IDX_W-1:0]          index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [IDX_W-1:0]          corner_b;
  logic [IDX_W-1:0]          corner_c;

  modport source(output valid, op, index, coord_x, coord_y, coord_z, corner_b, corner_c,
                 input ready);
  modport sink(input valid, op, index, coord_x, coord_y, coord_z, corner_b, corner_c,
               output ready);
endinterface

interface mvna_out_if;
  import mvna_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic [CNT_W-1:0]        share_count;

  modport source(output valid, normal_x, normal_y, normal_z, share_count, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, share_count, output ready);
endinterface

@@ sv/mvna_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_front
// Accepts items, range checks indexes and turns them into queue commands.
// ----------------------------------------------------------------------------
module mvna_front import mvna_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  mvna_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic rng_a, rng_b, rng_c, keep;
  cmd_kind_t kind;

  assign rng_a = 32'(in_ch.index) < VERTEX_DEPTH;
  assign rng_b = 32'(in_ch.corner_b) < VERTEX_DEPTH;
  assign rng_c = 32'(in_ch.corner_c) < VERTEX_DEPTH;

  always_comb begin
    kind = CMD_CLEAR;
    keep = 1'b0;
    unique case (op_t'(in_ch.op))
      OP_WRITE: begin
        kind = CMD_WRITE;
        keep = rng_a;
      end
      OP_TRI: begin
        kind = CMD_TRI;
        keep = rng_a && rng_b && rng_c;
      end
      OP_READ: begin
        kind = rng_a ? CMD_READ : CMD_READ_ZERO;
        keep = 1'b1;
      end
      OP_CLEAR: begin
        kind = CMD_CLEAR;
        keep = 1'b1;
      end
      default: begin
        kind = CMD_CLEAR;
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full && keep;

  always_comb begin
    q_cmd.kind  = kind;
    q_cmd.idx_a = in_ch.index;
    q_cmd.idx_b = in_ch.corner_b;
    q_cmd.idx_c = in_ch.corner_c;
    q_cmd.x     = in_ch.coord_x;
    q_cmd.y     = in_ch.coord_y;
    q_cmd.z     = in_ch.coord_z;
  end

endmodule

@@ sv/mvna_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mvna_cmd_fifo import mvna_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  output logic       full,
  input  logic       pop,
  output fifo_head_t head
);

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_W:0]   cnt_r;

  assign full       = cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign head.empty = cnt_r == '0;
  assign head.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

@@ sv/mvna_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_div
// Three-lane restoring divider, one quotient bit per cycle, clamped to 1.0.
// ----------------------------------------------------------------------------
module mvna_div import mvna_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [2:0][NUM_W-1:0]      num,
  input  logic [DIV_W-1:0]           den,
  output logic                       busy,
  output logic                       done,
  output logic [2:0][Q_W-1:0]        quo
);

  logic                  busy_r, done_r;
  logic [3:0]            cnt_r;
  logic [DIV_W-1:0]      den_r;
  logic [2:0][DIV_W-1:0] rem_r;
  logic [2:0][Q_W-1:0]   low_r;
  logic [2:0][Q_W-1:0]   qb_r;
  logic [2:0]            sat_r;
  logic [2:0][DIV_W:0]   rem2;
  logic [2:0][DIV_W:0]   diff;
  logic [2:0]            ge;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem2[i] = {rem_r[i], low_r[i][Q_W-1]};
      diff[i] = rem2[i] - {1'b0, den_r};
      ge[i]   = rem2[i] >= {1'b0, den_r};
      quo[i]  = (sat_r[i] || qb_r[i] > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : qb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 4'(Q_W-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= {1'b0, num[i][NUM_W-1:Q_W]};
        low_r[i] <= num[i][Q_W-1:0];
        sat_r[i] <= {1'b0, num[i][NUM_W-1:Q_W]} >= den;
        qb_r[i]  <= '0;
      end
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= ge[i] ? diff[i][DIV_W-1:0] : rem2[i][DIV_W-1:0];
        qb_r[i]  <= {qb_r[i][Q_W-2:0], ge[i]};
        low_r[i] <= {low_r[i][Q_W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

@@ sv/mvna_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_back
// Executes queued commands: vertex store, triangle normals, accumulation,
// averaged reads and clearing sweeps.
// ----------------------------------------------------------------------------
module mvna_back import mvna_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fifo_head_t  fifo,
  output logic        fifo_pop,
  mvna_out_if.source  out_ch
);

  localparam int ADDR_W = $clog2(VERTEX_DEPTH);
  localparam logic [SUM_W-1:0] SQRT_BIT0 = SUM_W'(1) << (SUM_W - 2);
  localparam int SQRT_STEPS = SUM_W / 2;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [IDX_W+ADDR_W-1:0] e;
    e = {{ADDR_W{1'b0}}, i};
    return e[ADDR_W-1:0];
  endfunction

  function automatic logic [MAG_W:0] split_mag(input logic [MAG_W:0] d);
    logic [MAG_W:0] n;
    n = (MAG_W+1)'(0) - d;
    return {d[MAG_W], d[MAG_W] ? n[MAG_W-1:0] : d[MAG_W-1:0]};
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [NRM_W-1:0] n);
    logic [ACC_W:0] t;
    t = {a[ACC_W-1], a} + {{(ACC_W-NRM_W+1){n[NRM_W-1]}}, n};
    if (t[ACC_W] != t[ACC_W-1])
      return t[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return t[ACC_W-1:0];
  endfunction

  back_state_t state_r, state_nxt;

  vert_t    vmem [VERTEX_DEPTH];
  acc_ent_t amem [VERTEX_DEPTH];
  vert_t    vrd_r;
  acc_ent_t ard_r;

  logic              vm_we;
  logic [ADDR_W-1:0] vm_ra, am_ra, am_wa;
  logic              am_we;
  acc_ent_t          am_wd;

  logic [ADDR_W-1:0]       clr_r;
  logic [2:0][ADDR_W-1:0]  corner_r;
  logic [1:0]              k_r;
  unit_phase_t             phase_r;
  vert_t                   va_r;
  logic [2:0][MAG_W:0]     d2_r;
  logic [2:0][MAG_W-1:0]   mag_r;
  logic [2:0]              neg_r;
  logic [SUM_W-1:0]        sum_r, rem_r, root_r, bit_r;
  logic [4:0]              it_r;
  logic [2:0][NRM_W-1:0]   e1_r, e2_r, n_r;
  logic [2:0]              rd_neg_r;
  logic [CNT_W-1:0]        rd_cnt_r;

  logic                    out_valid_r;
  logic [2:0][NRM_W-1:0]   out_n_r;
  logic [CNT_W-1:0]        out_cnt_r;

  logic                    div_start, div_busy, div_done;
  logic [2:0][NUM_W-1:0]   div_num;
  logic [DIV_W-1:0]        div_den;
  logic [2:0][Q_W-1:0]     div_q;
  logic [2:0][NRM_W-1:0]   q_signed;

  logic                    big;
  logic [2*(MAG_W-2)-1:0]  sq;
  logic [SUM_W-1:0]        sum_add, root_try;
  logic [MAG_W-2:0]        len1;
  logic [2:0][MAG_W:0]     d_ba, d_ca;
  logic [2:0][MAG_W:0]     rd_mag;
  logic signed [NRM_W-1:0] pa, pb, qa, qb;
  logic signed [MAG_W:0]   cdiff;
  logic                    head_read;

  mvna_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  // ---------------------------------------------------------------- datapath
  always_comb begin
    big      = |{mag_r[0][MAG_W-1:MAG_W-2], mag_r[1][MAG_W-1:MAG_W-2],
                 mag_r[2][MAG_W-1:MAG_W-2]};
    sq       = mag_r[k_r][MAG_W-3:0] * mag_r[k_r][MAG_W-3:0];
    sum_add  = sum_r + SUM_W'(sq);
    root_try = root_r + bit_r;
    len1     = (root_r[MAG_W-2:0] == '0) ? (MAG_W-1)'(1) : root_r[MAG_W-2:0];
    for (int i = 0; i < 3; i++) begin
      d_ba[i]     = {vrd_r[i][COORD_W-1], vrd_r[i]} - {va_r[i][COORD_W-1], va_r[i]};
      d_ca[i]     = d_ba[i];
      rd_mag[i]   = split_mag({ard_r.sum[i][ACC_W-1], ard_r.sum[i]});
      q_signed[i] = (phase_r == PH_FACE || phase_r == PH_EDGE1 || phase_r == PH_EDGE2)
                    && neg_r[i] ? NRM_W'(0) - {1'b0, div_q[i]} : {1'b0, div_q[i]};
    end
    unique case (k_r)
      2'd1: begin pa = e1_r[2]; pb = e2_r[0]; qa = e1_r[0]; qb = e2_r[2]; end
      2'd2: begin pa = e1_r[0]; pb = e2_r[1]; qa = e1_r[1]; qb = e2_r[0]; end
      default: begin pa = e1_r[1]; pb = e2_r[2]; qa = e1_r[2]; qb = e2_r[1]; end
    endcase
    cdiff = (MAG_W+1)'(pa * pb) - (MAG_W+1)'(qa * qb);
  end

  // ------------------------------------------------------------- next state
  assign head_read = fifo.head.kind == CMD_READ || fifo.head.kind == CMD_READ_ZERO;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (clr_r == ADDR_W'(VERTEX_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (!fifo.empty) begin
          priority case (fifo.head.kind)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_TRI:   state_nxt = ST_TV0;
            CMD_READ:  if (!out_valid_r) state_nxt = ST_RD_WAIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_WAIT: state_nxt = ST_RD_DIV;
      ST_RD_DIV:  if (div_done) state_nxt = ST_IDLE;
      ST_TV0:     state_nxt = ST_TV1;
      ST_TV1:     state_nxt = ST_TV2;
      ST_TV2:     state_nxt = ST_SHIFT;
      ST_SHIFT:   if (!big) state_nxt = ST_SQ;
      ST_SQ:      if (k_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT:    if (it_r == 5'(SQRT_STEPS - 1)) state_nxt = ST_ULEN;
      ST_ULEN:    state_nxt = ST_UDIV;
      ST_UDIV: begin
        if (div_done) begin
          priority case (phase_r)
            PH_EDGE1: state_nxt = ST_SHIFT;
            PH_EDGE2: state_nxt = ST_CROSS;
            default:  state_nxt = ST_ACC_R;
          endcase
        end
      end
      ST_CROSS:   if (k_r == 2'd2) state_nxt = ST_SHIFT;
      ST_ACC_R:   state_nxt = ST_ACC_W;
      ST_ACC_W:   state_nxt = (k_r == 2'd2) ? ST_IDLE : ST_ACC_R;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    fifo_pop  = 1'b0;
    vm_we     = 1'b0;
    vm_ra     = corner_r[0];
    am_ra     = corner_r[k_r];
    am_we     = 1'b0;
    am_wa     = corner_r[k_r];
    am_wd     = '0;
    div_start = 1'b0;
    div_den   = 32'(len1);
    for (int i = 0; i < 3; i++)
      div_num[i] = NUM_W'({mag_r[i][MAG_W-3:0], 14'b0}) + NUM_W'(len1[MAG_W-2:1]);
    unique case (state_r)
      ST_CLEAR: begin
        am_we = 1'b1;
        am_wa = clr_r;
      end
      ST_IDLE: begin
        vm_ra = to_addr(fifo.head.idx_a);
        am_ra = to_addr(fifo.head.idx_a);
        if (!fifo.empty) begin
          fifo_pop = !head_read || !out_valid_r;
          vm_we    = fifo.head.kind == CMD_WRITE;
        end
      end
      ST_RD_WAIT: begin
        div_start = 1'b1;
        div_den   = 32'(ard_r.cnt);
        for (int i = 0; i < 3; i++)
          div_num[i] = NUM_W'(rd_mag[i][MAG_W-1:0]) + NUM_W'(ard_r.cnt[CNT_W-1:1]);
      end
      ST_TV0:  vm_ra = corner_r[1];
      ST_TV1:  vm_ra = corner_r[2];
      ST_ULEN: div_start = 1'b1;
      ST_ACC_W: begin
        am_we = 1'b1;
        for (int i = 0; i < 3; i++) am_wd.sum[i] = sat_add(ard_r.sum[i], n_r[i]);
        am_wd.cnt = (ard_r.cnt == '1) ? ard_r.cnt : ard_r.cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (vm_we)
      vmem[to_addr(fifo.head.idx_a)] <= {fifo.head.z, fifo.head.y, fifo.head.x};
    vrd_r <= vmem[vm_ra];
  end

  always_ff @(posedge clk) begin
    if (am_we) amem[am_wa] <= am_wd;
    ard_r <= amem[am_ra];
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_IDLE && fifo_pop && fifo.head.kind == CMD_CLEAR) clr_r <= '0;
      if (state_r == ST_IDLE && fifo_pop && fifo.head.kind == CMD_READ_ZERO)
        out_valid_r <= 1'b1;
      else if (state_r == ST_RD_DIV && div_done)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        corner_r[0] <= to_addr(fifo.head.idx_a);
        corner_r[1] <= to_addr(fifo.head.idx_b);
        corner_r[2] <= to_addr(fifo.head.idx_c);
        if (fifo_pop && fifo.head.kind == CMD_READ_ZERO) begin
          out_n_r   <= '0;
          out_cnt_r <= '0;
        end
      end
      ST_RD_WAIT: begin
        rd_cnt_r <= ard_r.cnt;
        for (int i = 0; i < 3; i++) rd_neg_r[i] <= ard_r.sum[i][ACC_W-1];
      end
      ST_RD_DIV: begin
        if (div_done) begin
          out_cnt_r <= rd_cnt_r;
          for (int i = 0; i < 3; i++)
            out_n_r[i] <= (rd_cnt_r == '0) ? '0 :
                          rd_neg_r[i] ? NRM_W'(0) - {1'b0, div_q[i]} : {1'b0, div_q[i]};
        end
      end
      ST_TV0: va_r <= vrd_r;
      ST_TV1: begin
        phase_r <= PH_EDGE1;
        for (int i = 0; i < 3; i++) {neg_r[i], mag_r[i]} <= split_mag(d_ba[i]);
      end
      ST_TV2: for (int i = 0; i < 3; i++) d2_r[i] <= d_ca[i];
      ST_SHIFT: begin
        k_r   <= '0;
        sum_r <= '0;
        if (big) for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
      end
      ST_SQ: begin
        k_r    <= k_r + 1'b1;
        sum_r  <= sum_add;
        rem_r  <= sum_add;
        root_r <= '0;
        bit_r  <= SQRT_BIT0;
        it_r   <= '0;
      end
      ST_SQRT: begin
        if (rem_r >= root_try) begin
          rem_r  <= rem_r - root_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        it_r  <= it_r + 1'b1;
      end
      ST_UDIV: begin
        k_r <= '0;
        if (div_done) begin
          priority case (phase_r)
            PH_EDGE1: begin
              e1_r    <= q_signed;
              phase_r <= PH_EDGE2;
              for (int i = 0; i < 3; i++) {neg_r[i], mag_r[i]} <= split_mag(d2_r[i]);
            end
            PH_EDGE2: e2_r <= q_signed;
            default:  n_r  <= q_signed;
          endcase
        end
      end
      ST_CROSS: begin
        k_r <= k_r + 1'b1;
        {neg_r[k_r], mag_r[k_r]} <= split_mag(cdiff);
        if (k_r == 2'd2) phase_r <= PH_FACE;
      end
      ST_ACC_W: k_r <= k_r + 1'b1;
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.normal_x    = out_n_r[0];
  assign out_ch.normal_y    = out_n_r[1];
  assign out_ch.normal_z    = out_n_r[2];
  assign out_ch.share_count = out_cnt_r;

`ifndef ASSERT_OFF
  a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !fifo_pop)
    else $error("command popped during clearing sweep");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo.empty)
    else $error("pop from empty command queue");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_DIV && div_done) |-> !out_valid_r)
    else $error("result register overwritten");

  a_acc_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    am_we |-> (state_r == ST_CLEAR || state_r == ST_ACC_W))
    else $error("accumulator write outside sweep or update");
`endif

endmodule

@@ sv/mesh_vertex_normal_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_average
// Per-vertex normal averaging over a triangle mesh.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transfer: write vertex, add triangle,
//   read averaged normal, clear accumulators. out_ch carries one result per
//   read command. Both are valid/ready channels.
//   The front accepts items into a four-entry command queue whenever the
//   queue has room, so items keep flowing while a result waits on out_ch.
//   Steps per command in the back, from the queue pop: a vertex write
//   completes at the pop; a read runs the pop, the accumulator memory
//   read, then the 15-step divider and its done flag; a triangle runs
//   three normalizations (each a 31-step square root plus the divider)
//   with up to two range shifts per edge, the cross product and the
//   three read-modify-write accumulator updates.
//   Clear sweeps one accumulator entry per cycle.
//   After reset a clearing sweep runs before the first command
//   executes; up to four items are still queued meanwhile.
//   A stalled out_ch holds its result; further reads wait in the queue.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_average import mvna_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  mvna_in_if.sink    in_ch,
  mvna_out_if.source out_ch
);

  logic       q_push, q_full, q_pop;
  cmd_t       q_cmd;
  fifo_head_t q_head;

  mvna_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  mvna_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  mvna_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fifo     (q_head),
    .fifo_pop (q_pop),
    .out_ch   (out_ch)
  );

endmodule
